FILE: hdl/sbps_pkg.sv
package sbps_pkg;

    // Default sizes of the bone palette and the polygon vertex buffer
    localparam int PALETTE_SIZE_DEF       = 32;
    localparam int MAX_POLY_VERTS_DEF     = 8;

    // Bone ids carried by one vertex
    localparam int BONES_PER_VTX          = 4;
    localparam int BONE_IDX_W             = 2;
    localparam int BONE_W                 = 16;

    // Palette limit register
    localparam int LIMIT_W                = 6;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

    // Input item kinds
    localparam logic KIND_VERTEX          = 1'b0;
    localparam logic KIND_GROUP_END       = 1'b1;

    typedef logic [BONE_W-1:0] bone_t;
    typedef bone_t [BONES_PER_VTX-1:0] vtx_t;

    typedef enum logic [1:0] {
        RK_ENTRY  = 2'd0,
        RK_EOL    = 2'd1,
        RK_REJECT = 2'd2
    } result_kind_t;

endpackage

FILE: hdl/skin_bone_palette_splitter.sv
// Bone palette splitter for skinned polygons.
// Input: pulse start with kind, bone_0..bone_3 and last_vertex while busy is low;
// the item is taken at that edge and busy stays high until all its results are out.
// Configuration: cfg_we with cfg_data writes the palette limit (0 acts as 1, values
// above PALETTE_SIZE act as PALETTE_SIZE); write it only while busy is low.
// Results: one transfer per cycle marked by result_valid, with result_kind,
// bone_id, palette_slot and last; last flags the final result of an input item.
// The receiver has no back-pressure; every strobe is one transfer.
// Timing: one compare unit reads one palette slot per cycle from the palette RAM.
// Each bone of a vertex is compared with the palette slots in turn until it hits
// or the used slots run out, and every buffered vertex is replayed after a
// palette overflow. A closing vertex emits each palette entry its polygon added,
// read from the RAM in S_ERD and sent in S_EOUT. An end of group passes through
// S_GROUP and S_DONE. Each result waits in a holding register until the next one
// is ready or the item finishes; the final one leaves on the cycle busy drops.
// Reset: palette and polygon state clear, result_valid drops, and the palette
// limit returns to 32.
module skin_bone_palette_splitter
    import sbps_pkg::*;
#(
    parameter int PALETTE_SIZE         = PALETTE_SIZE_DEF,
    parameter int MAX_POLYGON_VERTICES = MAX_POLY_VERTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               kind,
    input  logic [15:0]        bone_0,
    input  logic [15:0]        bone_1,
    input  logic [15:0]        bone_2,
    input  logic [15:0]        bone_3,
    input  logic               last_vertex,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_data,
    output logic               result_valid,
    output logic [1:0]         result_kind,
    output logic [15:0]        bone_id,
    output logic [4:0]         palette_slot,
    output logic               last
);

    localparam int CNT_W = $clog2(PALETTE_SIZE + 1);
    localparam int AW    = $clog2(PALETTE_SIZE);
    localparam int VW    = $clog2(MAX_POLYGON_VERTICES + 1);
    localparam int VIW   = $clog2(MAX_POLYGON_VERTICES);
    localparam int LW    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam logic [BONE_IDX_W-1:0] LAST_BONE = BONE_IDX_W'(BONES_PER_VTX - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_GROUP = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_TAIL  = 7'b0001000,
        S_ERD   = 7'b0010000,
        S_EOUT  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [LIMIT_W-1:0]     limit_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       base_reg, base_next;
    logic [VW-1:0]          vcount_reg, vcount_next;
    logic                   failed_reg, failed_next;
    logic                   lastv_reg, lastv_next;
    logic [BONE_IDX_W-1:0]  bone_idx_reg, bone_idx_next;
    logic [CNT_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                   cmp_pend_reg, cmp_pend_next;
    logic                   rebuild_reg, rebuild_next;
    logic [VW-1:0]          v_reg, v_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic                   result_valid_reg, result_valid_next;
    logic                   res_last_reg, res_last_next;

    // Payload registers
    vtx_t                   cur_vtx_reg, cur_vtx_next;
    vtx_t                   buffer_reg [0:MAX_POLYGON_VERTICES-1];
    logic                   buf_we;
    result_kind_t           pend_kind_reg;
    bone_t                  pend_bone_reg;
    logic [CNT_W-1:0]       pend_slot_reg;
    result_kind_t           res_kind_reg;
    bone_t                  res_bone_reg;
    logic [CNT_W-1:0]       res_slot_reg;

    // Result push from the sequencer
    logic                   push;
    result_kind_t           push_kind;
    bone_t                  push_bone;
    logic [CNT_W-1:0]       push_slot;

    // Palette RAM and shared compare unit
    logic                   ram_we;
    bone_t                  ram_rdata;
    bone_t                  bone_cur;
    logic                   hit;
    logic [LW-1:0]          lim_ext;
    logic [CNT_W-1:0]       eff_lim;
    logic [VW-1:0]          v_inc;
    logic [CNT_W-1:0]       scan_inc;
    vtx_t                   in_vtx;

    sbps_ram #(
        .WIDTH (BONE_W),
        .DEPTH (PALETTE_SIZE)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (bone_cur),
        .raddr (scan_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Clamp the configured limit into 1..PALETTE_SIZE
    always_comb
    begin
        lim_ext = LW'(limit_reg);
        if (limit_reg == '0)
        begin
            eff_lim = CNT_W'(1);
        end
        else if (lim_ext > LW'(PALETTE_SIZE))
        begin
            eff_lim = CNT_W'(PALETTE_SIZE);
        end
        else
        begin
            eff_lim = CNT_W'(lim_ext);
        end
    end

    assign in_vtx   = {bone_3, bone_2, bone_1, bone_0};
    assign bone_cur = cur_vtx_reg[bone_idx_reg];
    assign hit      = cmp_pend_reg && (ram_rdata == bone_cur);
    assign v_inc    = v_reg + 1'b1;
    assign scan_inc = scan_idx_reg + 1'b1;

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        base_next     = base_reg;
        vcount_next   = vcount_reg;
        failed_next   = failed_reg;
        lastv_next    = lastv_reg;
        bone_idx_next = bone_idx_reg;
        scan_idx_next = scan_idx_reg;
        cmp_pend_next = 1'b0;
        rebuild_next  = rebuild_reg;
        v_next        = v_reg;
        cur_vtx_next  = cur_vtx_reg;
        buf_we        = 1'b0;
        ram_we        = 1'b0;
        push          = 1'b0;
        push_kind     = RK_ENTRY;
        push_bone     = '0;
        push_slot     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    lastv_next   = last_vertex;
                    cur_vtx_next = in_vtx;
                    if (kind == KIND_GROUP_END)
                    begin
                        // Report an open polygon before the end of list
                        if (vcount_reg != '0 || failed_reg)
                        begin
                            push      = 1'b1;
                            push_kind = RK_REJECT;
                        end
                        state_next = S_GROUP;
                    end
                    else if (failed_reg)
                    begin
                        state_next = S_TAIL;
                    end
                    else if (vcount_reg >= VW'(MAX_POLYGON_VERTICES))
                    begin
                        count_next  = base_reg;
                        failed_next = 1'b1;
                        state_next  = S_TAIL;
                    end
                    else
                    begin
                        buf_we        = 1'b1;
                        vcount_next   = vcount_reg + 1'b1;
                        bone_idx_next = '0;
                        scan_idx_next = '0;
                        rebuild_next  = 1'b0;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_GROUP:
            begin
                push        = 1'b1;
                push_kind   = RK_EOL;
                count_next  = '0;
                base_next   = '0;
                vcount_next = '0;
                failed_next = 1'b0;
                state_next  = S_DONE;
            end

            S_SCAN:
            begin
                if (!hit && scan_idx_reg < count_reg)
                begin
                    // Issue the next slot read; compare it next cycle
                    scan_idx_next = scan_inc;
                    cmp_pend_next = 1'b1;
                end
                else if (!hit && count_reg >= eff_lim)
                begin
                    // Palette overflow
                    if (rebuild_reg || base_reg == '0)
                    begin
                        count_next  = base_reg;
                        failed_next = 1'b1;
                        state_next  = S_TAIL;
                    end
                    else
                    begin
                        push          = 1'b1;
                        push_kind     = RK_EOL;
                        count_next    = '0;
                        base_next     = '0;
                        rebuild_next  = 1'b1;
                        v_next        = '0;
                        cur_vtx_next  = buffer_reg[0];
                        bone_idx_next = '0;
                        scan_idx_next = '0;
                    end
                end
                else
                begin
                    // Bone found, or appended in the next free slot
                    if (!hit)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    scan_idx_next = '0;
                    if (bone_idx_reg != LAST_BONE)
                    begin
                        bone_idx_next = bone_idx_reg + 1'b1;
                    end
                    else if (rebuild_reg && v_inc < vcount_reg)
                    begin
                        v_next        = v_inc;
                        cur_vtx_next  = buffer_reg[v_inc[VIW-1:0]];
                        bone_idx_next = '0;
                    end
                    else
                    begin
                        state_next = S_TAIL;
                    end
                end
            end

            S_TAIL:
            begin
                if (!lastv_reg)
                begin
                    state_next = S_DONE;
                end
                else if (failed_reg)
                begin
                    push        = 1'b1;
                    push_kind   = RK_REJECT;
                    vcount_next = '0;
                    failed_next = 1'b0;
                    state_next  = S_DONE;
                end
                else if (base_reg == count_reg)
                begin
                    vcount_next = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    scan_idx_next = base_reg;
                    state_next    = S_ERD;
                end
            end

            S_ERD:
            begin
                state_next = S_EOUT;
            end

            S_EOUT:
            begin
                // Emit one entry that this polygon added
                push          = 1'b1;
                push_kind     = RK_ENTRY;
                push_bone     = ram_rdata;
                push_slot     = scan_idx_reg;
                scan_idx_next = scan_inc;
                if (scan_inc == count_reg)
                begin
                    base_next   = count_reg;
                    vcount_next = '0;
                    failed_next = 1'b0;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_ERD;
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold each result until the next one or the finish so the final one can carry last
    always_comb
    begin
        result_valid_next = 1'b0;
        res_last_next     = 1'b0;
        pend_valid_next   = pend_valid_reg;
        if (push)
        begin
            result_valid_next = pend_valid_reg;
            pend_valid_next   = 1'b1;
        end
        else if (state_reg == S_DONE)
        begin
            result_valid_next = pend_valid_reg;
            res_last_next     = 1'b1;
            pend_valid_next   = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            limit_reg        <= LIMIT_RESET;
            count_reg        <= '0;
            base_reg         <= '0;
            vcount_reg       <= '0;
            failed_reg       <= 1'b0;
            lastv_reg        <= 1'b0;
            bone_idx_reg     <= '0;
            scan_idx_reg     <= '0;
            cmp_pend_reg     <= 1'b0;
            rebuild_reg      <= 1'b0;
            v_reg            <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            res_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            count_reg        <= count_next;
            base_reg         <= base_next;
            vcount_reg       <= vcount_next;
            failed_reg       <= failed_next;
            lastv_reg        <= lastv_next;
            bone_idx_reg     <= bone_idx_next;
            scan_idx_reg     <= scan_idx_next;
            cmp_pend_reg     <= cmp_pend_next;
            rebuild_reg      <= rebuild_next;
            v_reg            <= v_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
            res_last_reg     <= res_last_next;
        end
    end

    // Payload registers: vertex buffer, pending result, output result
    always_ff @(posedge clk)
    begin
        cur_vtx_reg <= cur_vtx_next;
        if (buf_we)
        begin
            buffer_reg[vcount_reg[VIW-1:0]] <= in_vtx;
        end
        if (push)
        begin
            pend_kind_reg <= push_kind;
            pend_bone_reg <= push_bone;
            pend_slot_reg <= push_slot;
        end
        if (result_valid_next)
        begin
            res_kind_reg <= pend_kind_reg;
            res_bone_reg <= pend_bone_reg;
            res_slot_reg <= pend_slot_reg;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result_kind  = res_kind_reg;
    assign bone_id      = res_bone_reg;
    assign palette_slot = 5'(res_slot_reg);
    assign last         = res_last_reg;

`ifndef NO_ASSERTIONS
    // Results only leave while an item is in work or as it finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
    else $error("result outside an item");

    // An accepted item raises busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
    else $error("item accepted without busy");

    // Palette count stays within the palette
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PALETTE_SIZE))
    else $error("palette count beyond size");

    // Polygon base never passes the palette count
    assert property (@(posedge clk) disable iff (!rst_n)
        base_reg <= count_reg)
    else $error("polygon base beyond palette count");

    // Vertex buffer never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= VW'(MAX_POLYGON_VERTICES))
    else $error("vertex buffer overfilled");
`endif

endmodule

FILE: hdl/sbps_ram.sv
module sbps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
